### src/euclidean_gate_step_sequencer_macros.svh
// Assertion helpers used by the checker.
`ifndef EUCLIDEAN_GATE_STEP_SEQUENCER_MACROS_SVH
`define EUCLIDEAN_GATE_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define EGSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EGSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/egss_pkg.sv
`default_nettype none
package egss_pkg;

	localparam int SC_W     = 5;
	localparam int FC_W     = 6;
	localparam int ROT_W    = 4;
	localparam int IDX_W    = 4;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;
	localparam int MAX_STEPS_DEF = 16;

	localparam logic [1:0] REG_STEP_COUNT = 2'd0;
	localparam logic [1:0] REG_FILL_COUNT = 2'd1;
	localparam logic [1:0] REG_ROTATION   = 2'd2;

	localparam logic [SC_W-1:0]  STEP_COUNT_RST = SC_W'(8);
	localparam logic [FC_W-1:0]  FILL_COUNT_RST = '0;
	localparam logic [ROT_W-1:0] ROTATION_RST   = '0;

	typedef struct packed {
		logic [SC_W-1:0]         step_count;
		logic signed [FC_W-1:0]  fill_count;
		logic [ROT_W-1:0]        rotation;
	} cfg_t;

endpackage
`default_nettype wire

### src/egss_cfg.sv
`default_nettype none
module egss_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [egss_pkg::APB_AW-1:0]   paddr,
	input  wire logic [egss_pkg::APB_DW-1:0]   pwdata,
	output logic      [egss_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output egss_pkg::cfg_t                     cfg
);
	import egss_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_sel;

	assign reg_sel = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_count <= STEP_COUNT_RST;
			cfg_q.fill_count <= FILL_COUNT_RST;
			cfg_q.rotation   <= ROTATION_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_STEP_COUNT: cfg_q.step_count <= pwdata[SC_W-1:0];
				REG_FILL_COUNT: cfg_q.fill_count <= pwdata[FC_W-1:0];
				REG_ROTATION:   cfg_q.rotation   <= pwdata[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_STEP_COUNT: prdata = APB_DW'(cfg_q.step_count);
			REG_FILL_COUNT: prdata = APB_DW'(cfg_q.fill_count);
			REG_ROTATION:   prdata = APB_DW'(cfg_q.rotation);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### src/egss_mod.sv
`default_nettype none
// Restoring remainder, one dividend bit per cycle.
module egss_mod #(
	parameter int PW = 5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [2*PW-1:0] dividend,
	input  wire logic [PW-1:0]   divisor,
	output logic                 done,
	output logic [PW-1:0]        rem
);
	localparam int DW = 2 * PW;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] div_q;
	logic [PW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [PW:0]   trial;
	logic [PW:0]   diff;
	logic [PW-1:0] rem_nxt;

	assign trial   = {rem_q, div_q[DW-1]};
	assign diff    = trial - {1'b0, divisor};
	assign rem_nxt = (trial >= {1'b0, divisor}) ? diff[PW-1:0] : trial[PW-1:0];
	assign done    = done_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			div_q <= {div_q[DW-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

endmodule
`default_nettype wire

### src/egss_ctrl.sv
`default_nettype none
module egss_ctrl #(
	parameter int MAX_STEPS = egss_pkg::MAX_STEPS_DEF,
	parameter int PW        = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire egss_pkg::cfg_t               cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         in_trigger,
	input  wire logic                         in_reset,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [egss_pkg::IDX_W-1:0]        out_step,
	output logic                              out_gate,
	output logic                              out_loop,
	output logic                              mod_start,
	output logic [2*PW-1:0]                   mod_dividend,
	output logic [PW-1:0]                     mod_divisor,
	input  wire logic                         mod_done,
	input  wire logic [PW-1:0]                mod_rem
);
	import egss_pkg::*;

	localparam int NMAX = (MAX_STEPS < 31) ? MAX_STEPS : 31;
	localparam int DW   = 2 * PW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WPOS  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_PGO   = 3'd4;
	localparam logic [2:0] ST_WPROD = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]       state_q;
	logic [PW-1:0]    pos_q;
	logic             started_q;
	logic [PW-1:0]    n_q;
	logic [PW-1:0]    p_q;
	logic [PW-1:0]    i_q;
	logic             inv_q;
	logic [DW-1:0]    prod_q;
	logic             gate_q;
	logic             ov_q;
	logic [IDX_W-1:0] ostep_q;
	logic             ogate_q;
	logic             oloop_q;

	logic [PW-1:0]    n_c;
	logic             accept;
	logic             run_mod;
	logic             spec_c;
	logic             spec_gate_c;
	logic             inv_c;
	logic [PW-1:0]    p_c;
	logic [PW-1:0]    i_c;
	logic [PW:0]      hit_sum;
	logic             emit_go;
	int               n_i, f_i, mag_i, rot_i, idx_i;

	always_comb begin
		if (int'(cfg.step_count) > NMAX) n_c = PW'(NMAX);
		else if (cfg.step_count < SC_W'(2)) n_c = PW'(2);
		else n_c = PW'(cfg.step_count);
	end

	always_comb begin
		n_i = int'(n_q);
		f_i = int'(cfg.fill_count);
		if (f_i > n_i) f_i = n_i;
		if (f_i < -n_i) f_i = -n_i;
		mag_i = (f_i < 0) ? -f_i : f_i;
		rot_i = int'(cfg.rotation);
		if (rot_i > n_i - 1) rot_i = n_i - 1;
		idx_i = int'(pos_q) + n_i - rot_i;
		if (idx_i >= n_i) idx_i = idx_i - n_i;
		spec_c      = (f_i == 0) || (mag_i == n_i);
		spec_gate_c = (f_i == n_i);
		inv_c       = (f_i > 0);
		p_c         = PW'(n_i - mag_i);
		i_c         = PW'(idx_i);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign run_mod  = accept & in_trigger & ~in_reset & started_q;
	assign emit_go  = (state_q == ST_EMIT) & (~ov_q | out_ready);
	assign hit_sum  = {1'b0, mod_rem} + {1'b0, p_q};

	assign mod_start    = run_mod | (state_q == ST_PGO);
	assign mod_dividend = (state_q == ST_PGO) ? prod_q : DW'({1'b0, pos_q} + 1'b1);
	assign mod_divisor  = (state_q == ST_IDLE) ? n_c : n_q;

	assign out_valid = ov_q;
	assign out_step  = ostep_q;
	assign out_gate  = ogate_q;
	assign out_loop  = oloop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			started_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (emit_go) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (run_mod) begin
							state_q <= ST_WPOS;
						end else if (in_trigger) begin
							pos_q     <= '0;
							started_q <= 1'b1;
							state_q   <= ST_PREP;
						end else if (in_reset) begin
							started_q <= 1'b0;
							pos_q     <= '0;
						end
					end
				end
				ST_WPOS: begin
					if (mod_done) begin
						pos_q   <= mod_rem;
						state_q <= ST_PREP;
					end
				end
				ST_PREP:  state_q <= spec_c ? ST_EMIT : ST_MUL;
				ST_MUL:   state_q <= ST_PGO;
				ST_PGO:   state_q <= ST_WPROD;
				ST_WPROD: if (mod_done) state_q <= ST_EMIT;
				ST_EMIT:  if (emit_go) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) n_q <= n_c;
		if (state_q == ST_PREP) begin
			p_q    <= p_c;
			i_q    <= i_c;
			inv_q  <= inv_c;
			gate_q <= spec_gate_c;
		end
		if (state_q == ST_MUL) prod_q <= p_q * i_q;
		if (state_q == ST_WPROD && mod_done) gate_q <= (hit_sum >= {1'b0, n_q}) ^ inv_q;
		if (emit_go) begin
			ostep_q <= IDX_W'(pos_q);
			ogate_q <= gate_q;
			oloop_q <= (pos_q == '0);
		end
	end

endmodule
`default_nettype wire

### src/euclidean_gate_step_sequencer.sv
// Accept to result valid: two passes through the shared bit-serial remainder unit, first
// (pos+1) mod N, then (p*i) mod N; the first step after a reset skips the first pass, an
// all-on/all-off fill skips the second, and both together skip both.
// Input: after a trigger beat no beat is taken until its result enters the output register,
// which waits on a stalled earlier result; after a beat with no trigger the input stays ready.
// Reset: arst_n clears control, registers go to 8/0/0, and the next trigger gives step 0.
`default_nettype none
module euclidean_gate_step_sequencer #(
	parameter int MAX_STEPS = egss_pkg::MAX_STEPS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // trigger_event, reset_event
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // step_index[3:0], gate_main, loop_start
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [egss_pkg::APB_AW-1:0]  paddr,
	input  wire logic [egss_pkg::APB_DW-1:0]  pwdata,
	output logic      [egss_pkg::APB_DW-1:0]  prdata,
	output logic                              pready
);
	import egss_pkg::*;

	localparam int NMAX = (MAX_STEPS < 31) ? MAX_STEPS : 31;
	localparam int PW   = $clog2(NMAX + 1);

	cfg_t             cfg;
	logic             mod_start;
	logic [2*PW-1:0]  mod_dividend;
	logic [PW-1:0]    mod_divisor;
	logic             mod_done;
	logic [PW-1:0]    mod_rem;
	logic [IDX_W-1:0] out_step;
	logic             out_gate;
	logic             out_loop;

	egss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	egss_mod #(.PW(PW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	egss_ctrl #(.MAX_STEPS(MAX_STEPS), .PW(PW)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_trigger   (s_axis_tdata[0]),
		.in_reset     (s_axis_tdata[1]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_step     (out_step),
		.out_gate     (out_gate),
		.out_loop     (out_loop),
		.mod_start    (mod_start),
		.mod_dividend (mod_dividend),
		.mod_divisor  (mod_divisor),
		.mod_done     (mod_done),
		.mod_rem      (mod_rem)
	);

	assign m_axis_tdata = {2'b00, out_loop, out_gate, out_step};

endmodule
`default_nettype wire

### src/egss_checker.sv
`default_nettype none
`include "euclidean_gate_step_sequencer_macros.svh"
module egss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	`EGSS_ASSERT_NEXT(a_busy_after_trig, s_axis_tvalid && s_axis_tready && s_axis_tdata[0], !s_axis_tready, "ready high right after a trigger beat")
	`EGSS_ASSERT_NEXT(a_idle_after_plain, s_axis_tvalid && s_axis_tready && !s_axis_tdata[0], s_axis_tready, "not ready after a beat without trigger")
	`EGSS_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:6] == 2'b00, "output pad bits set")
	`EGSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

endmodule

bind euclidean_gate_step_sequencer egss_checker u_egss_checker (.*);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
module tb;
	import egss_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] step_index;
		logic             gate_main;
		logic             loop_start;
	} step_res_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;  // trigger_event, reset_event
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;  // step_index[3:0], gate_main, loop_start
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	euclidean_gate_step_sequencer u_dut (.*);

	// sequencer state as seen by the testbench
	logic [SC_W-1:0]        cur_steps;
	logic signed [FC_W-1:0] cur_fill;
	logic [ROT_W-1:0]       cur_rot;
	int unsigned            seq_pos;
	bit                     seq_running;

	step_res_t expected_steps[$];
	step_res_t got_step;
	step_res_t want_step;
	int        mismatches;
	int        beats_sent;
	int        rdy_run;
	int        rdy_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(21, 60);
	endfunction

	function automatic int loop_steps();
		if (cur_steps < 2) return 2;
		if (cur_steps > MAX_STEPS_DEF) return MAX_STEPS_DEF;
		return int'(cur_steps);
	endfunction

	function automatic bit pattern_gate(int pos, int n);
		int f;
		int mag;
		int p;
		int rot;
		int i;
		bit hit;
		f = cur_fill;
		if (f > n) f = n;
		if (f < -n) f = -n;
		if (f == 0 || f == -n) return 1'b0;
		if (f == n) return 1'b1;
		mag = (f < 0) ? -f : f;
		p = n - mag;
		rot = cur_rot;
		if (rot > n - 1) rot = n - 1;
		i = (pos + n - rot) % n;
		hit = (((p * i) % n) + p >= n);
		return (f > 0) ? !hit : hit;
	endfunction

	task automatic advance_sequence(bit trig, bit rst);
		int n;
		step_res_t r;
		n = loop_steps();
		if (rst) begin
			seq_running = 1'b0;
			seq_pos = 0;
		end
		if (!trig) return;
		if (!seq_running) begin
			seq_pos = 0;
			seq_running = 1'b1;
		end else begin
			seq_pos = (seq_pos + 1) % n;
		end
		r.step_index = seq_pos[IDX_W-1:0];
		r.gate_main = pattern_gate(seq_pos, n);
		r.loop_start = (seq_pos == 0);
		expected_steps.push_back(r);
	endtask

	task automatic note_failure(string msg);
		mismatches++;
		if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_step = {m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[5]};
			if (expected_steps.size() == 0) begin
				note_failure($sformatf("unexpected result step=%0d gate=%0b start=%0b",
					got_step.step_index, got_step.gate_main, got_step.loop_start));
			end else begin
				want_step = expected_steps.pop_front();
				if (got_step.step_index !== want_step.step_index ||
					got_step.gate_main !== want_step.gate_main ||
					got_step.loop_start !== want_step.loop_start) begin
					note_failure($sformatf(
						"result mismatch: exp step=%0d gate=%0b start=%0b, got step=%0d gate=%0b start=%0b",
						want_step.step_index, want_step.gate_main, want_step.loop_start,
						got_step.step_index, got_step.gate_main, got_step.loop_start));
				end
			end
		end
	end

	// output backpressure
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 4) == 0) rdy_run = $urandom_range(100, 300);
			else rdy_run = $urandom_range(1, 30);
			repeat (rdy_run - 1) @(negedge clk);
			rdy_hold = pick_gap();
			if (rdy_hold > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (rdy_hold - 1) @(negedge clk);
			end
		end
	end

	task automatic send_beat(bit trig, bit rst);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, rst, trig};
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
		advance_sequence(trig, rst);
	endtask

	task automatic idle_sender(int cycles);
		if (cycles == 0) return;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_steps.size() != 0) @(posedge clk);
	endtask

	// drain, then cover beats that make no result but may still be in flight
	task automatic settle();
		drain();
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_STEP_COUNT: cur_steps = val[SC_W-1:0];
			REG_FILL_COUNT: cur_fill = val[FC_W-1:0];
			REG_ROTATION:   cur_rot = val[ROT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(int sc, int fc, int rot);
		settle();
		write_reg(REG_STEP_COUNT, 32'(sc) & 32'h1F);
		write_reg(REG_FILL_COUNT, 32'(fc) & 32'h3F);
		write_reg(REG_ROTATION, 32'(rot) & 32'hF);
	endtask

	task automatic test_reset_defaults();
		send_beat(1'b1, 1'b0);
		send_beat(1'b1, 1'b0);
		send_beat(1'b0, 1'b0);
		send_beat(1'b0, 1'b1);
		send_beat(1'b1, 1'b0);
		send_beat(1'b1, 1'b1);
	endtask

	task automatic test_fill_extremes();
		configure(16, 16, 0);
		repeat (2) send_beat(1'b1, 1'b0);
		configure(31, -32, 15);
		repeat (2) send_beat(1'b1, 1'b0);
		configure(0, 31, 15);
		send_beat(1'b1, 1'b0);
		configure(7, -3, 15);
		repeat (3) send_beat(1'b1, 1'b0);
	endtask

	task automatic test_loop_shortened();
		configure(10, 5, 3);
		send_beat(1'b1, 1'b1);
		repeat (7) send_beat(1'b1, 1'b0);
		configure(4, 1, 0);
		repeat (2) send_beat(1'b1, 1'b0);
	endtask

	task automatic random_config();
		int sc;
		int n;
		int fc;
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) sc = $urandom_range(2, 16);
		else if (r == 7) sc = 2;
		else if (r == 8) sc = 16;
		else sc = $urandom_range(0, 31);
		n = (sc < 2) ? 2 : ((sc > MAX_STEPS_DEF) ? MAX_STEPS_DEF : sc);
		r = $urandom_range(0, 19);
		if (r < 5) fc = int'($urandom_range(0, 63)) - 32;
		else if (r == 5) fc = 0;
		else if (r == 6) fc = n;
		else if (r == 7) fc = -n;
		else fc = int'($urandom_range(0, 2 * n)) - n;
		configure(sc, fc, $urandom_range(0, 15));
	endtask

	task automatic test_random_phases(int target);
		int phase_len;
		int pause_at;
		int k;
		int r;
		bit quiet;
		while (beats_sent < target) begin
			random_config();
			phase_len = $urandom_range(20, 120);
			pause_at = $urandom_range(0, phase_len - 1);
			quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < phase_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 70) send_beat(1'b1, 1'b0);
				else if (r < 80) send_beat(1'b1, 1'b1);
				else if (r < 88) send_beat(1'b0, 1'b1);
				else send_beat(1'b0, 1'b0);
				if (k == pause_at) drain();
				else if (!quiet) idle_sender(pick_gap());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_steps = STEP_COUNT_RST;
		cur_fill = FILL_COUNT_RST;
		cur_rot = ROTATION_RST;
		seq_pos = 0;
		seq_running = 1'b0;
		mismatches = 0;
		beats_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_fill_extremes();
		test_loop_shortened();
		test_random_phases(beats_sent + 1750);
		settle();

		if (mismatches == 0 && expected_steps.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/egss_pkg.sv
src/egss_cfg.sv
src/egss_mod.sv
src/egss_ctrl.sv
src/euclidean_gate_step_sequencer.sv
src/egss_checker.sv
dv/tb.sv
